// ===== rtl/core/slrf_pkg.sv =====
// Package with shared constants and types for the resampler.
`default_nettype none
package slrf_pkg;
  localparam int MaxRunOutputs = 16;
  localparam int FadeMaxFrames = 96;
  localparam int FadeMinFrames = 16;
  localparam int PhaseFracBits = 32;
  localparam int PhaseW = 37;
  localparam int FadeW = 7;
  localparam int SampleW = 16;
  localparam int RunCntW = $clog2(MaxRunOutputs + 1);

  localparam logic [0:0] CfgPhaseStep = 1'b0;
  localparam logic [0:0] CfgFadeFrames = 1'b1;

  localparam logic [1:0] RestartNone = 2'd0;
  localparam logic [1:0] RestartFade = 2'd1;

  typedef logic signed [SampleW-1:0] sample_t;

  typedef struct packed {
    logic load;
    logic start_mul;
    logic start_div;
    logic emit;
    logic finish;
  } dp_cmd_t;

  typedef struct packed {
    logic first_frame;
    logic run_more;
    logic fading;
    logic mul_done;
    logic div_done;
  } dp_sts_t;
endpackage
`default_nettype wire

// ===== rtl/core/slrf_if.sv =====
// Valid/ready channel interfaces for frames, results and configuration writes.
`default_nettype none
interface slrf_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] left_sample;
  logic signed [15:0] right_sample;
  logic [1:0] restart;
  modport source(output valid, left_sample, right_sample, restart, input ready);
  modport sink(input valid, left_sample, right_sample, restart, output ready);
endinterface

interface slrf_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] out_left;
  logic signed [15:0] out_right;
  logic last;
  modport source(output valid, out_left, out_right, last, input ready);
  modport sink(input valid, out_left, out_right, last, output ready);
endinterface

interface slrf_cfg_if;
  logic valid;
  logic ready;
  logic index;
  logic [36:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/stereo_linear_resampler_fade.sv =====
// Top level of the stereo linear resampler with fade-in after restart.
// Channel | Dir | Payload
// in_     | in  | left_sample, right_sample, restart
// out_    | out | out_left, out_right, last
// cfg_    | in  | index (0 phase_step, 1 fade_frames), data
// A frame that is the first or a restart is only stored. Otherwise each output is a
// multiply, then a divide in the bit-serial fade divider when it is faded, then emit;
// each frame also has accept, the final run check and finish.
// Reset is synchronous; previous samples, history valid, phase and fade counters clear.
// An output waits in its register while the next output is computed; a stalled
// output holds the controller before the following one.
`default_nettype none
module stereo_linear_resampler_fade (
  input  wire logic clk,
  input  wire logic rst_n,
  slrf_in_if.sink in_ch,
  slrf_out_if.source out_ch,
  slrf_cfg_if.sink cfg_ch
);
  import slrf_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic idle, out_vld;

  assign in_ch.ready = idle;
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = out_vld;

  slrf_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n),
    .in_fire(in_ch.valid && idle),
    .out_taken(out_vld && out_ch.ready),
    .sts(sts), .cmd(cmd), .idle(idle), .out_vld(out_vld)
  );

  slrf_datapath u_dp (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_ch.valid), .cfg_idx(cfg_ch.index), .cfg_data(cfg_ch.data),
    .in_l(in_ch.left_sample), .in_r(in_ch.right_sample), .in_rs(in_ch.restart),
    .cmd(cmd), .sts(sts),
    .res_l(out_ch.out_left), .res_r(out_ch.out_right), .res_last(out_ch.last)
  );
endmodule
`default_nettype wire

// ===== rtl/core/slrf_datapath.sv =====
// Resampler datapath: history, phase, interpolation multiply and serial fade divide.
`default_nettype none
module slrf_datapath (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic cfg_we,
  input  wire logic cfg_idx,
  input  wire logic [36:0] cfg_data,
  input  wire logic signed [15:0] in_l,
  input  wire logic signed [15:0] in_r,
  input  wire logic [1:0] in_rs,
  input  wire slrf_pkg::dp_cmd_t cmd,
  output slrf_pkg::dp_sts_t sts,
  output logic signed [15:0] res_l,
  output logic signed [15:0] res_r,
  output logic res_last
);
  import slrf_pkg::*;

  localparam logic [PhaseW-1:0] One = PhaseW'(64'd1 << PhaseFracBits);
  localparam logic [PhaseW-1:0] PhaseMax = '1;
  localparam int DivW = 24;

  logic [PhaseW-1:0] step_r, phase_r;
  logic [FadeW-1:0] fade_cfg_r, rem_r, tot_r;
  logic signed [15:0] prev_l_r, prev_r_r, cur_l_r, cur_r_r, lo_l_r, lo_r_r;
  logic hist_vld_r, have_lo_r;
  logic [RunCntW-1:0] n_r;
  logic signed [15:0] il_r, ir_r;
  logic [DivW-1:0] ql_r, qr_r, reml_r, remr_r, numl_r, numr_r;
  logic negl_r, negr_r;
  logic [4:0] dcnt_r;
  logic dbusy_r, ddone_r, mdone_r;
  logic [FadeW-1:0] fclamp;
  logic [PhaseFracBits-1:0] frac;
  logic signed [17:0] dl, dr;
  logic signed [50:0] pl_r, pr_r;
  logic signed [15:0] from_l, from_r;
  logic signed [17:0] fdl, fdr;
  logic [FadeW-1:0] done_c;
  logic [FadeW:0] den;
  logic signed [DivW:0] fpl, fpr;
  logic [DivW-1:0] absl, absr;
  logic [DivW:0] tl, tr;
  logic signed [15:0] fl, fr;
  logic [PhaseW:0] psum;

  assign fclamp = (fade_cfg_r < FadeW'(FadeMinFrames)) ? FadeW'(FadeMinFrames) :
                  (fade_cfg_r > FadeW'(FadeMaxFrames)) ? FadeW'(FadeMaxFrames) : fade_cfg_r;
  assign frac = phase_r[PhaseFracBits-1:0];
  assign dl = 18'(cur_l_r) - 18'(prev_l_r);
  assign dr = 18'(cur_r_r) - 18'(prev_r_r);
  assign from_l = have_lo_r ? lo_l_r : 16'sd0;
  assign from_r = have_lo_r ? lo_r_r : 16'sd0;
  assign fdl = 18'(il_r) - 18'(from_l);
  assign fdr = 18'(ir_r) - 18'(from_r);
  assign done_c = tot_r - rem_r + FadeW'(1);
  assign den = {1'b0, tot_r} + (FadeW+1)'(1);
  assign fpl = (DivW+1)'(fdl) * (DivW+1)'($signed({1'b0, done_c}));
  assign fpr = (DivW+1)'(fdr) * (DivW+1)'($signed({1'b0, done_c}));
  assign absl = fpl[DivW] ? DivW'(-fpl) : DivW'(fpl);
  assign absr = fpr[DivW] ? DivW'(-fpr) : DivW'(fpr);
  assign tl = {reml_r, numl_r[DivW-1]} - (DivW+1)'(den);
  assign tr = {remr_r, numr_r[DivW-1]} - (DivW+1)'(den);
  assign fl = from_l + (negl_r ? -16'(ql_r) : 16'(ql_r));
  assign fr = from_r + (negr_r ? -16'(qr_r) : 16'(qr_r));
  assign psum = {1'b0, phase_r} + {1'b0, step_r};

  assign sts.first_frame = !hist_vld_r || (in_rs != RestartNone);
  assign sts.run_more = (phase_r < One) && (n_r < RunCntW'(MaxRunOutputs));
  assign sts.fading = (rem_r != '0) && (tot_r != '0);
  assign sts.mul_done = mdone_r;
  assign sts.div_done = ddone_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= One;
      fade_cfg_r <= FadeW'(48);
      phase_r <= '0;
      hist_vld_r <= 1'b0;
      have_lo_r <= 1'b0;
      rem_r <= '0;
      tot_r <= '0;
      prev_l_r <= '0;
      prev_r_r <= '0;
      lo_l_r <= '0;
      lo_r_r <= '0;
      dbusy_r <= 1'b0;
      ddone_r <= 1'b0;
      mdone_r <= 1'b0;
      n_r <= '0;
    end else begin
      mdone_r <= 1'b0;
      ddone_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_idx == CfgPhaseStep) step_r <= cfg_data;
        else fade_cfg_r <= cfg_data[FadeW-1:0];
      end
      if (cmd.load) begin
        cur_l_r <= in_l;
        cur_r_r <= in_r;
        n_r <= '0;
        if (in_rs != RestartNone) begin
          phase_r <= '0;
          rem_r <= (in_rs == RestartFade) ? fclamp : '0;
          tot_r <= (in_rs == RestartFade) ? fclamp : '0;
        end
        if (!hist_vld_r || in_rs != RestartNone) begin
          prev_l_r <= in_l;
          prev_r_r <= in_r;
          hist_vld_r <= 1'b1;
        end
      end
      if (cmd.start_mul) begin
        pl_r <= dl * $signed({1'b0, frac});
        pr_r <= dr * $signed({1'b0, frac});
        mdone_r <= 1'b1;
      end
      if (mdone_r) begin
        il_r <= prev_l_r + 16'(pl_r >>> PhaseFracBits);
        ir_r <= prev_r_r + 16'(pr_r >>> PhaseFracBits);
      end
      if (cmd.start_div) begin
        numl_r <= absl;
        numr_r <= absr;
        negl_r <= fdl[17];
        negr_r <= fdr[17];
        reml_r <= '0;
        remr_r <= '0;
        dcnt_r <= 5'(DivW);
        dbusy_r <= 1'b1;
      end else if (dbusy_r) begin
        numl_r <= {numl_r[DivW-2:0], 1'b0};
        numr_r <= {numr_r[DivW-2:0], 1'b0};
        ql_r <= {ql_r[DivW-2:0], !tl[DivW]};
        qr_r <= {qr_r[DivW-2:0], !tr[DivW]};
        reml_r <= tl[DivW] ? {reml_r[DivW-2:0], numl_r[DivW-1]} : tl[DivW-1:0];
        remr_r <= tr[DivW] ? {remr_r[DivW-2:0], numr_r[DivW-1]} : tr[DivW-1:0];
        dcnt_r <= dcnt_r - 5'd1;
        if (dcnt_r == 5'd1) begin
          dbusy_r <= 1'b0;
          ddone_r <= 1'b1;
        end
      end
      if (cmd.emit) begin
        res_l <= sts.fading ? fl : il_r;
        res_r <= sts.fading ? fr : ir_r;
        lo_l_r <= sts.fading ? fl : il_r;
        lo_r_r <= sts.fading ? fr : ir_r;
        have_lo_r <= 1'b1;
        if (sts.fading) rem_r <= rem_r - FadeW'(1);
        n_r <= n_r + RunCntW'(1);
        phase_r <= psum[PhaseW] ? PhaseMax : psum[PhaseW-1:0];
        res_last <= !(((psum[PhaseW] ? PhaseMax : psum[PhaseW-1:0]) < One) &&
                      (n_r + RunCntW'(1) < RunCntW'(MaxRunOutputs)));
      end
      if (cmd.finish) begin
        phase_r <= (phase_r >= One) ? phase_r - One : '0;
        prev_l_r <= cur_l_r;
        prev_r_r <= cur_r_r;
      end
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/slrf_ctrl.sv =====
// Resampler controller state machine sequencing load, multiply, divide and output.
`default_nettype none
module slrf_ctrl (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_fire,
  input  wire logic out_taken,
  input  wire slrf_pkg::dp_sts_t sts,
  output slrf_pkg::dp_cmd_t cmd,
  output logic idle,
  output logic out_vld
);
  import slrf_pkg::*;

  localparam logic [2:0] SIdle = 3'd0;
  localparam logic [2:0] SLoad = 3'd1;
  localparam logic [2:0] SMul = 3'd2;
  localparam logic [2:0] SDiv = 3'd3;
  localparam logic [2:0] SEmit = 3'd4;
  localparam logic [2:0] SOut = 3'd5;
  localparam logic [2:0] SFin = 3'd6;
  localparam logic [2:0] SWait = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic out_vld_r, out_vld_nxt;

  assign idle = (state_r == SIdle);
  assign out_vld = out_vld_r;

  always_comb begin
    state_nxt = state_r;
    out_vld_nxt = out_vld_r;
    cmd = '0;
    unique case (state_r)
      SIdle: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          state_nxt = sts.first_frame ? SWait : SLoad;
        end
      end
      SWait: state_nxt = SIdle;
      SLoad: begin
        if (sts.run_more) begin
          cmd.start_mul = 1'b1;
          state_nxt = SMul;
        end else begin
          state_nxt = SFin;
        end
      end
      SMul: begin
        if (sts.mul_done) state_nxt = SDiv;
      end
      SDiv: begin
        cmd.start_div = sts.fading;
        state_nxt = sts.fading ? SEmit : SOut;
      end
      SEmit: begin
        if (sts.div_done) state_nxt = SOut;
      end
      SOut: begin
        if (!out_vld_r) begin
          cmd.emit = 1'b1;
          out_vld_nxt = 1'b1;
          state_nxt = SLoad;
        end
      end
      SFin: begin
        cmd.finish = 1'b1;
        state_nxt = SIdle;
      end
      default: state_nxt = SIdle;
    endcase
    if (out_taken) out_vld_nxt = 1'b0;
    if (cmd.emit) out_vld_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SIdle;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== rtl/core/slrf_checker.sv =====
// Port-level assertions for the resampler, bound to the top level.
`default_nettype none
module slrf_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_last
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_last)) else $error("last changed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice");
endmodule

bind stereo_linear_resampler_fade slrf_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_last(out_ch.last)
);
`default_nettype wire
